### sv/crwd_pkg.sv
package crwd_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_REQUEST = 2'd1;
   localparam logic [1:0] MODE_DONE = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_NOWORK = 3'd4;
   localparam logic [2:0] ST_UNKNOWN = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DIV,
      S_GRANT,
      S_UPD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       scan_next;
      logic       div_init;
      logic       div_step;
      logic       write_add;
      logic       write_grant;
      logic       write_done;
      logic       res_load;
      logic [2:0] res_status;
      logic       res_fin;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       empty_range;
      logic       bad_range;
      logic       scan_hit;
      logic       scan_end;
      logic       table_full;
      logic       div_last;
      logic       done_finish;
      logic       rsp_busy;
   } stat_type;

endpackage

### sv/crwd_ctrl.sv
module crwd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  crwd_pkg::stat_type stat,
   output crwd_pkg::cmd_type  cmd
);
   import crwd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            case (stat.mode)
               MODE_ADD: begin
                  if (stat.empty_range) begin
                     cmd.res_load = 1'b1;
                     cmd.res_status = ST_EMPTY;
                     cmd.res_fin = 1'b1;
                     state_in = S_OUT;
                  end else if (stat.bad_range || stat.scan_hit) begin
                     cmd.res_load = 1'b1;
                     cmd.res_status = ST_INVALID;
                     state_in = S_OUT;
                  end else if (stat.scan_end) begin
                     cmd.res_load = 1'b1;
                     if (stat.table_full) begin
                        cmd.res_status = ST_FULL;
                     end else begin
                        cmd.res_status = ST_OK;
                        cmd.write_add = 1'b1;
                     end
                     state_in = S_OUT;
                  end else begin
                     cmd.scan_next = 1'b1;
                  end
               end
               MODE_REQUEST: begin
                  if (stat.scan_hit) begin
                     cmd.div_init = 1'b1;
                     state_in = S_DIV;
                  end else if (stat.scan_end) begin
                     cmd.res_load = 1'b1;
                     cmd.res_status = ST_NOWORK;
                     state_in = S_OUT;
                  end else begin
                     cmd.scan_next = 1'b1;
                  end
               end
               MODE_DONE: begin
                  if (stat.scan_hit) begin
                     state_in = S_UPD;
                  end else if (stat.scan_end) begin
                     cmd.res_load = 1'b1;
                     cmd.res_status = ST_UNKNOWN;
                     state_in = S_OUT;
                  end else begin
                     cmd.scan_next = 1'b1;
                  end
               end
               default: begin
                  cmd.res_load = 1'b1;
                  cmd.res_status = ST_INVALID;
                  state_in = S_OUT;
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            cmd.write_grant = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_status = ST_OK;
            state_in = S_OUT;
         end
         S_UPD: begin
            cmd.write_done = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_fin = stat.done_finish;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### sv/crwd_datapath.sv
module crwd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_task_id,
   input  logic               req_filter_enable,
   input  logic [31:0]        req_range_begin,
   input  logic [31:0]        req_range_end,
   input  logic [31:0]        req_done_count,
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data,
   input  crwd_pkg::cmd_type  cmd,
   output crwd_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_granted,
   output logic [7:0]         rsp_granted_task,
   output logic [31:0]        rsp_chunk_begin,
   output logic [31:0]        rsp_chunk_end,
   output logic               rsp_task_finished
);
   import crwd_pkg::*;

   logic [6:0]  workers_ff;
   logic [1:0]  mode_ff;
   logic [7:0]  tag_ff;
   logic        filt_ff;
   logic [31:0] begin_ff, end_ff, done_ff;

   logic [7:0]  etag_ff [TABLE_DEPTH];
   logic [31:0] estart_ff [TABLE_DEPTH];
   logic [31:0] elen_ff [TABLE_DEPTH];
   logic [31:0] eiss_ff [TABLE_DEPTH];
   logic [31:0] efin_ff [TABLE_DEPTH];
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] idx_ff;

   logic [31:0] dq_ff;
   logic [6:0]  rem_ff;
   logic [4:0]  dcnt_ff;

   logic [2:0]  res_status_ff;
   logic        res_fin_ff, res_grant_ff;
   logic [7:0]  res_task_ff;
   logic [31:0] res_cb_ff, res_ce_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic        rsp_granted_ff, rsp_fin_ff;
   logic [7:0]  rsp_task_ff;
   logic [31:0] rsp_cb_ff, rsp_ce_ff;

   logic [IDX_W-1:0] ridx;
   logic [7:0]  cur_tag;
   logic [31:0] cur_start, cur_len, cur_iss, cur_fin;
   logic        in_table, match;
   logic [6:0]  wdiv;
   logic [7:0]  trial;
   logic        qbit;
   logic [6:0]  rem_in;
   logic [31:0] part, need, cb;
   logic [32:0] sum_wide;
   logic [31:0] sum_sat;

   assign ridx = idx_ff[IDX_W-1:0];
   assign cur_tag = etag_ff[ridx];
   assign cur_start = estart_ff[ridx];
   assign cur_len = elen_ff[ridx];
   assign cur_iss = eiss_ff[ridx];
   assign cur_fin = efin_ff[ridx];
   assign in_table = (idx_ff < fill_ff);

   always_comb begin
      case (mode_ff)
         MODE_REQUEST: match = (!filt_ff || cur_tag == tag_ff) && (cur_iss < cur_len);
         default: match = (cur_tag == tag_ff);
      endcase
   end

   assign wdiv = (workers_ff == 7'd0) ? 7'd1 : workers_ff;
   assign trial = {rem_ff, dq_ff[31]};
   assign qbit = (trial >= {1'b0, wdiv});
   assign rem_in = qbit ? 7'(trial - {1'b0, wdiv}) : trial[6:0];

   assign need = cur_len - cur_iss;
   always_comb begin
      part = (dq_ff == 32'd0) ? 32'd1 : dq_ff;
      if (part > need) begin
         part = need;
      end
   end
   assign cb = cur_start + cur_iss;

   assign sum_wide = {1'b0, cur_fin} + {1'b0, done_ff};
   assign sum_sat = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

   always_comb begin
      stat.mode = mode_ff;
      stat.empty_range = (begin_ff == end_ff);
      stat.bad_range = (begin_ff > end_ff);
      stat.scan_hit = in_table && match;
      stat.scan_end = !in_table;
      stat.table_full = (fill_ff == CNT_W'(TABLE_DEPTH));
      stat.div_last = (dcnt_ff == 5'd31);
      stat.done_finish = (sum_sat >= cur_len);
      stat.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         workers_ff <= 7'd1;
      end else if (csr_write_enable) begin
         workers_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         tag_ff <= req_task_id;
         filt_ff <= req_filter_enable;
         begin_ff <= req_range_begin;
         end_ff <= req_range_end;
         done_ff <= req_done_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= '0;
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dq_ff <= cur_len;
         rem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff <= {dq_ff[30:0], qbit};
         rem_ff <= rem_in;
         dcnt_ff <= dcnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.write_add) begin
         fill_ff <= fill_ff + CNT_W'(1);
      end else if (cmd.write_done && stat.done_finish) begin
         fill_ff <= fill_ff - CNT_W'(1);
      end
   end

   // table: append at the fill point, drop by shifting later entries down
   always_ff @(posedge clock) begin
      if (cmd.write_add) begin
         etag_ff[fill_ff[IDX_W-1:0]] <= tag_ff;
         estart_ff[fill_ff[IDX_W-1:0]] <= begin_ff;
         elen_ff[fill_ff[IDX_W-1:0]] <= end_ff - begin_ff;
         eiss_ff[fill_ff[IDX_W-1:0]] <= '0;
         efin_ff[fill_ff[IDX_W-1:0]] <= '0;
      end else if (cmd.write_grant) begin
         eiss_ff[ridx] <= cur_iss + part;
      end else if (cmd.write_done) begin
         if (stat.done_finish) begin
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
               if (IDX_W'(i) >= ridx) begin
                  etag_ff[i] <= etag_ff[i + 1];
                  estart_ff[i] <= estart_ff[i + 1];
                  elen_ff[i] <= elen_ff[i + 1];
                  eiss_ff[i] <= eiss_ff[i + 1];
                  efin_ff[i] <= efin_ff[i + 1];
               end
            end
         end else begin
            efin_ff[ridx] <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_grant_ff <= 1'b0;
         res_task_ff <= '0;
         res_cb_ff <= '0;
         res_ce_ff <= '0;
      end else if (cmd.write_grant) begin
         res_grant_ff <= 1'b1;
         res_task_ff <= cur_tag;
         res_cb_ff <= cb;
         res_ce_ff <= cb + part;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_fin_ff <= cmd.res_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_granted_ff <= res_grant_ff;
         rsp_task_ff <= res_task_ff;
         rsp_cb_ff <= res_cb_ff;
         rsp_ce_ff <= res_ce_ff;
         rsp_fin_ff <= res_fin_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_granted_task = rsp_task_ff;
   assign rsp_chunk_begin = rsp_cb_ff;
   assign rsp_chunk_end = rsp_ce_ff;
   assign rsp_task_finished = rsp_fin_ff;

endmodule

### sv/chunked_range_work_distributor.sv
// Work distributor over a table of 16 pending index ranges. One request at a
// time: the table is searched one entry per cycle. A work request that is
// served then goes through a bit-serial division of the range length by
// worker_count and a write of the granted chunk. A result waits in an output
// register; the next request is taken once the result has been loaded there,
// so a stalled result holds off the request after it. worker_count must be
// written through csr_ only while idle; the block itself does not enforce it.
module chunked_range_work_distributor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_task_id,
   input  logic        req_filter_enable,
   input  logic [31:0] req_range_begin,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_done_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_granted,
   output logic [7:0]  rsp_granted_task,
   output logic [31:0] rsp_chunk_begin,
   output logic [31:0] rsp_chunk_end,
   output logic        rsp_task_finished,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);
   import crwd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   crwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   crwd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_task_id       (req_task_id),
      .req_filter_enable (req_filter_enable),
      .req_range_begin   (req_range_begin),
      .req_range_end     (req_range_end),
      .req_done_count    (req_done_count),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted       (rsp_granted),
      .rsp_granted_task  (rsp_granted_task),
      .rsp_chunk_begin   (rsp_chunk_begin),
      .rsp_chunk_end     (rsp_chunk_end),
      .rsp_task_finished (rsp_task_finished)
   );

endmodule
